### src/wpid_pkg.sv
package wpid_pkg;

   localparam int INTEG_WIN = 64;
   localparam int DERIV_WIN = 16;

   localparam int POS_W     = 14;
   localparam int ERR_W     = POS_W + 1;
   localparam int DIFF_W    = ERR_W + 1;
   localparam int GAIN_W    = 16;
   localparam int SUM_W     = ERR_W + 1 + $clog2(INTEG_WIN);
   localparam int OPA_W     = 29;
   localparam int PROD_W    = OPA_W + GAIN_W + 1;
   localparam int DIV_W     = PROD_W;
   localparam int QUO_W     = DIV_W + 1;
   localparam int ACC_W     = QUO_W + 2;
   localparam int OUT_W     = 32;
   localparam int CNT_W     = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W = 8;
   localparam int IADDR_W   = $clog2(INTEG_WIN);
   localparam int DADDR_W   = $clog2(DERIV_WIN);

   localparam logic [POS_W-1:0] ENC_RAIL = 14'h3FFF;

   typedef enum logic [2:0] {
      REG_PROP_NUM, REG_PROP_DEN, REG_INTEG_NUM, REG_INTEG_DEN,
      REG_DERIV_NUM, REG_DERIV_DEN, REG_RATE, REG_OFFSET
   } csr_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0]        prop_num;
      logic [GAIN_W-1:0]        prop_den;
      logic [GAIN_W-1:0]        integ_num;
      logic [GAIN_W-1:0]        integ_den;
      logic [GAIN_W-1:0]        deriv_num;
      logic [GAIN_W-1:0]        deriv_den;
      logic [GAIN_W-1:0]        rate;
      logic signed [GAIN_W-1:0] offset;
   } csr_type;

   typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_type;

   typedef enum logic [1:0] {MSEL_RATE, MSEL_P, MSEL_I, MSEL_D} msel_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_RATE, ST_INTEG_WAIT,
      ST_TERM_MUL, ST_TERM_DIV, ST_TERM_WAIT, ST_RESULT
   } state_type;

   typedef struct packed {
      logic     load_in;
      logic     update;
      logic     mul_en;
      msel_type mul_sel;
      logic     div_load;
      logic     div_sum;
      logic     cap_terms;
      logic     acc_add;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } stat_type;

   function automatic logic [GAIN_W-1:0] nonzero(input logic [GAIN_W-1:0] v);
      return (v == '0) ? GAIN_W'(1) : v;
   endfunction

endpackage

### src/wpid_ram.sv
module wpid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/wpid_ctrl.sv
module wpid_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wpid_pkg::stat_type stat,
   output wpid_pkg::cmd_type  cmd
);

   wpid_pkg::state_type state_ff, state_in;
   wpid_pkg::term_type  term_ff, term_in;
   wpid_pkg::msel_type  term_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpid_pkg::ST_IDLE;
         term_ff  <= wpid_pkg::TERM_P;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      unique case (term_ff)
         wpid_pkg::TERM_P: term_sel = wpid_pkg::MSEL_P;
         wpid_pkg::TERM_I: term_sel = wpid_pkg::MSEL_I;
         wpid_pkg::TERM_D: term_sel = wpid_pkg::MSEL_D;
         default:          term_sel = wpid_pkg::MSEL_P;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      unique case (state_ff)
         wpid_pkg::ST_IDLE: begin
            if (req_valid) state_in = wpid_pkg::ST_FETCH;
         end
         wpid_pkg::ST_FETCH:   state_in = wpid_pkg::ST_RATE;
         wpid_pkg::ST_RATE:    state_in = wpid_pkg::ST_INTEG_WAIT;
         wpid_pkg::ST_INTEG_WAIT: begin
            if (!stat.div_busy) begin
               state_in = wpid_pkg::ST_TERM_MUL;
               term_in  = wpid_pkg::TERM_P;
            end
         end
         wpid_pkg::ST_TERM_MUL: state_in = wpid_pkg::ST_TERM_DIV;
         wpid_pkg::ST_TERM_DIV: state_in = wpid_pkg::ST_TERM_WAIT;
         wpid_pkg::ST_TERM_WAIT: begin
            if (!stat.div_busy) begin
               unique case (term_ff)
                  wpid_pkg::TERM_P: begin
                     term_in  = wpid_pkg::TERM_I;
                     state_in = wpid_pkg::ST_TERM_MUL;
                  end
                  wpid_pkg::TERM_I: begin
                     term_in  = wpid_pkg::TERM_D;
                     state_in = wpid_pkg::ST_TERM_MUL;
                  end
                  default: state_in = wpid_pkg::ST_RESULT;
               endcase
            end
         end
         wpid_pkg::ST_RESULT: begin
            if (stat.out_free) state_in = wpid_pkg::ST_IDLE;
         end
         default: state_in = wpid_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         wpid_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         wpid_pkg::ST_FETCH: cmd.update = 1'b1;
         wpid_pkg::ST_RATE: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = wpid_pkg::MSEL_RATE;
            cmd.div_load = 1'b1;
            cmd.div_sum  = 1'b1;
         end
         wpid_pkg::ST_INTEG_WAIT: begin
            cmd.mul_sel   = wpid_pkg::MSEL_RATE;
            cmd.cap_terms = !stat.div_busy;
         end
         wpid_pkg::ST_TERM_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = term_sel;
         end
         wpid_pkg::ST_TERM_DIV: begin
            cmd.mul_sel  = term_sel;
            cmd.div_load = 1'b1;
         end
         wpid_pkg::ST_TERM_WAIT: begin
            cmd.mul_sel = term_sel;
            cmd.acc_add = !stat.div_busy;
         end
         wpid_pkg::ST_RESULT: cmd.out_load = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

### src/wpid_datapath.sv
module wpid_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wpid_pkg::cmd_type                   cmd,
   output wpid_pkg::stat_type                  stat,
   input  wpid_pkg::csr_type                   csr,
   input  logic [wpid_pkg::POS_W-1:0]          req_actual_position,
   input  logic [wpid_pkg::POS_W-1:0]          req_desired_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wpid_pkg::OUT_W-1:0]   rsp_drive_value,
   output logic                                rsp_encoder_fault
);

   localparam int ERR_W  = wpid_pkg::ERR_W;
   localparam int PROD_W = wpid_pkg::PROD_W;
   localparam int DIV_W  = wpid_pkg::DIV_W;
   localparam int QUO_W  = wpid_pkg::QUO_W;
   localparam int ACC_W  = wpid_pkg::ACC_W;
   localparam int OPA_W  = wpid_pkg::OPA_W;
   localparam int GAIN_W = wpid_pkg::GAIN_W;
   localparam int SUM_W  = wpid_pkg::SUM_W;
   localparam int OUT_W  = wpid_pkg::OUT_W;

   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);
   localparam logic signed [PROD_W-1:0] DerivWin = PROD_W'(wpid_pkg::DERIV_WIN);

   // tick inputs
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic                    fault_ff;

   // history and moving sum
   logic [wpid_pkg::IADDR_W-1:0] islot_ff;
   logic [wpid_pkg::DADDR_W-1:0] dslot_ff;
   logic [wpid_pkg::INTEG_WIN-1:0] ival_ff;
   logic [wpid_pkg::DERIV_WIN-1:0] dval_ff;
   logic [ERR_W-1:0] irdata, drdata;
   logic signed [ERR_W-1:0] old_i, old_d;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [wpid_pkg::DIFF_W-1:0] diff_ff;

   // multiplier
   logic signed [OPA_W-1:0]  mul_a, erri_ff, errd_ff;
   logic [GAIN_W-1:0]        mul_b, divisor_sel;
   logic signed [PROD_W-1:0] prod_ff, prod_in, errd_full;

   // divider
   logic                     busy_ff, neg_ff;
   logic [wpid_pkg::CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]         quo_ff, dvd_mag;
   logic [GAIN_W-1:0]        rem_ff, dsr_ff;
   logic [GAIN_W:0]          rem_sh;
   logic [GAIN_W+1:0]        trial;
   logic signed [PROD_W-1:0] dvd;
   logic signed [QUO_W-1:0]  quo_s;

   // accumulator and result
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [OUT_W-1:0]  sat_val;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  drive_ff;
   logic                     fault_out_ff;

   assign err_in = $signed({1'b0, req_actual_position})
                 - $signed({1'b0, req_desired_position});

   wpid_ram #(.WIDTH(ERR_W), .DEPTH(wpid_pkg::INTEG_WIN)) u_integ_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (islot_ff),
      .wdata (err_ff),
      .raddr (islot_ff),
      .rdata (irdata)
   );

   wpid_ram #(.WIDTH(ERR_W), .DEPTH(wpid_pkg::DERIV_WIN)) u_deriv_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (dslot_ff),
      .wdata (err_ff),
      .raddr (dslot_ff),
      .rdata (drdata)
   );

   // entries never written read as zero
   assign old_i  = ival_ff[islot_ff] ? $signed(irdata) : '0;
   assign old_d  = dval_ff[dslot_ff] ? $signed(drdata) : '0;
   assign sum_in = sum_ff - SUM_W'(old_i) + SUM_W'(err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         islot_ff <= '0;
         dslot_ff <= '0;
         ival_ff  <= '0;
         dval_ff  <= '0;
         sum_ff   <= '0;
      end else if (cmd.update) begin
         ival_ff[islot_ff] <= 1'b1;
         dval_ff[dslot_ff] <= 1'b1;
         sum_ff            <= sum_in;
         islot_ff <= (islot_ff == wpid_pkg::IADDR_W'(wpid_pkg::INTEG_WIN - 1)) ?
                     '0 : islot_ff + 1'b1;
         dslot_ff <= (dslot_ff == wpid_pkg::DADDR_W'(wpid_pkg::DERIV_WIN - 1)) ?
                     '0 : dslot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         err_ff   <= err_in;
         fault_ff <= (req_actual_position == '0) ||
                     (req_actual_position == wpid_pkg::ENC_RAIL);
      end
      if (cmd.update) begin
         diff_ff <= wpid_pkg::DIFF_W'(err_ff) - wpid_pkg::DIFF_W'(old_d);
      end
   end

   // operand select for the shared multiplier and divider
   always_comb begin
      unique case (cmd.mul_sel)
         wpid_pkg::MSEL_RATE: begin
            mul_a       = OPA_W'(diff_ff);
            mul_b       = wpid_pkg::nonzero(csr.rate);
            divisor_sel = wpid_pkg::nonzero(csr.rate);
         end
         wpid_pkg::MSEL_P: begin
            mul_a       = OPA_W'(err_ff);
            mul_b       = csr.prop_num;
            divisor_sel = wpid_pkg::nonzero(csr.prop_den);
         end
         wpid_pkg::MSEL_I: begin
            mul_a       = erri_ff;
            mul_b       = csr.integ_num;
            divisor_sel = wpid_pkg::nonzero(csr.integ_den);
         end
         wpid_pkg::MSEL_D: begin
            mul_a       = errd_ff;
            mul_b       = csr.deriv_num;
            divisor_sel = wpid_pkg::nonzero(csr.deriv_den);
         end
         default: begin
            mul_a       = '0;
            mul_b       = '0;
            divisor_sel = GAIN_W'(1);
         end
      endcase
   end

   assign prod_in   = mul_a * $signed({1'b0, mul_b});
   assign errd_full = prod_ff / DerivWin;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.cap_terms) begin
         erri_ff <= quo_s[OPA_W-1:0];
         errd_ff <= errd_full[OPA_W-1:0];
      end
   end

   // shift-subtract divider on magnitudes, one quotient bit per cycle
   assign dvd     = cmd.div_sum ? PROD_W'(sum_ff) : prod_ff;
   assign dvd_mag = dvd[PROD_W-1] ? DIV_W'(-dvd) : DIV_W'(dvd);
   assign rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign quo_s   = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.div_load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= wpid_pkg::CNT_W'(DIV_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == wpid_pkg::CNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= dvd_mag;
         rem_ff <= '0;
         dsr_ff <= divisor_sel;
         neg_ff <= dvd[PROD_W-1];
      end else if (busy_ff) begin
         if (!trial[GAIN_W+1]) begin
            rem_ff <= trial[GAIN_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[GAIN_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         acc_ff <= ACC_W'(csr.offset);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(quo_s);
      end
   end

   always_comb begin
      priority if (acc_ff > SAT_MAX) begin
         sat_val = OUT_W'(SAT_MAX);
      end else if (acc_ff < SAT_MIN) begin
         sat_val = OUT_W'(SAT_MIN);
      end else begin
         sat_val = acc_ff[OUT_W-1:0];
      end
   end

   // result word register, frees the engine while the word waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         drive_ff     <= fault_ff ? OUT_W'(csr.offset) : sat_val;
         fault_out_ff <= fault_ff;
      end
   end

   assign stat.div_busy     = busy_ff;
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_value   = drive_ff;
   assign rsp_encoder_fault = fault_out_ff;

endmodule

### src/windowed_pid_joint_controller.sv
// an accepted word passes one fetch, one rate multiply, then four 46-bit divides on the
// shared shift-subtract divider, each with its load and wait states, and one result
// state before its result word is loaded
// the single divider keeps the next word out until this word is done; the next word is
// taken while a finished result still waits in the output register
// reset: synchronous, active high; control, CSR and window registers return to their
// defaults, histories read as zero through per-entry valid bits, no clearing pass
module windowed_pid_joint_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wpid_pkg::POS_W-1:0]            req_actual_position,
   input  logic [wpid_pkg::POS_W-1:0]            req_desired_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [wpid_pkg::OUT_W-1:0]     rsp_drive_value,
   output logic                                  rsp_encoder_fault,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wpid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wpid_pkg::GAIN_W-1:0]           csr_data
);

   wpid_pkg::csr_type  csr_ff;
   wpid_pkg::cmd_type  cmd;
   wpid_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.prop_num  <= wpid_pkg::GAIN_W'(1);
         csr_ff.prop_den  <= wpid_pkg::GAIN_W'(1);
         csr_ff.integ_num <= '0;
         csr_ff.integ_den <= wpid_pkg::GAIN_W'(1);
         csr_ff.deriv_num <= '0;
         csr_ff.deriv_den <= wpid_pkg::GAIN_W'(1);
         csr_ff.rate      <= wpid_pkg::GAIN_W'(1000);
         csr_ff.offset    <= '0;
      end else if (csr_valid && csr_ready &&
                   (csr_index[wpid_pkg::CSR_IDX_W-1:3] == '0)) begin
         unique case (wpid_pkg::csr_reg_type'(csr_index[2:0]))
            wpid_pkg::REG_PROP_NUM:  csr_ff.prop_num  <= csr_data;
            wpid_pkg::REG_PROP_DEN:  csr_ff.prop_den  <= csr_data;
            wpid_pkg::REG_INTEG_NUM: csr_ff.integ_num <= csr_data;
            wpid_pkg::REG_INTEG_DEN: csr_ff.integ_den <= csr_data;
            wpid_pkg::REG_DERIV_NUM: csr_ff.deriv_num <= csr_data;
            wpid_pkg::REG_DERIV_DEN: csr_ff.deriv_den <= csr_data;
            wpid_pkg::REG_RATE:      csr_ff.rate      <= csr_data;
            wpid_pkg::REG_OFFSET:    csr_ff.offset    <= $signed(csr_data);
            default:                 csr_ff.rate      <= csr_ff.rate;
         endcase
      end
   end

   wpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wpid_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr                  (csr_ff),
      .req_actual_position  (req_actual_position),
      .req_desired_position (req_desired_position),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drive_value      (rsp_drive_value),
      .rsp_encoder_fault    (rsp_encoder_fault)
   );

`ifndef NO_ASSERTIONS
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.div_busy)
      else $error("divider busy while engine idle");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine took a second word during a tick");

   a_fault_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_encoder_fault) |->
         (rsp_drive_value == wpid_pkg::OUT_W'(csr_ff.offset)))
      else $error("fault result not equal to drive offset");
`endif

endmodule

### bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  POS_MAX     = 16383;
   localparam int  GAP_MAX     = 4;
   localparam int  STALL_LIMIT = 5000;
   localparam int  DRAIN_WAIT  = 250;
   localparam int  PHASES      = 8;
   localparam int  PHASE_TICKS = 211;
   localparam int  PLAN_LEN    = 27;
   localparam logic [wpid_pkg::CSR_IDX_W-1:0] IDX_PAST_END = wpid_pkg::CSR_IDX_W'(8);
   localparam logic [wpid_pkg::CSR_IDX_W-1:0] IDX_TOP      = 8'hFF;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic [wpid_pkg::CSR_IDX_W-1:0]    idx;
      logic [wpid_pkg::POS_W-1:0]        act;
      logic [wpid_pkg::GAIN_W-1:0]       val;
      bit                                typed;
      logic signed [wpid_pkg::OUT_W-1:0] drv;
      logic                              flt;
   } plan_row_type;

   typedef struct {
      logic signed [wpid_pkg::OUT_W-1:0] drv;
      logic                              flt;
   } drive_word_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [wpid_pkg::POS_W-1:0]          req_actual_position;
   logic [wpid_pkg::POS_W-1:0]          req_desired_position;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [wpid_pkg::OUT_W-1:0]   rsp_drive_value;
   logic                                rsp_encoder_fault;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [wpid_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [wpid_pkg::GAIN_W-1:0]         csr_data;

   // joint model state
   logic [wpid_pkg::GAIN_W-1:0]         gain_reg [0:7];
   longint                              integ_err [0:wpid_pkg::INTEG_WIN-1];
   longint                              deriv_err [0:wpid_pkg::DERIV_WIN-1];
   longint                              integ_acc;
   int                                  integ_pos;
   int                                  deriv_pos;

   drive_word_type            drive_q [$];
   int                        fails;
   int                        checked;
   int                        faults_seen;
   int                        clipped_seen;
   int                        idle_cycles;
   bit                        no_idle;

   plan_row_type plan [0:PLAN_LEN-1] = '{
      '{ROW_TICK, 0, 8191, 8191, 1, 0, 0},
      '{ROW_TICK, 0, 16382, 1, 1, 16381, 0},
      '{ROW_TICK, 0, 1, 16382, 1, -16381, 0},
      '{ROW_TICK, 0, 0, 100, 1, 0, 1},
      '{ROW_TICK, 0, 16383, 0, 1, 0, 1},
      '{ROW_TICK, 0, 16383, 16383, 1, 0, 1},
      '{ROW_TICK, 0, 10922, 5461, 1, 5461, 0},
      '{ROW_TICK, 0, 5461, 10922, 1, -5461, 0},
      '{ROW_CSR, wpid_pkg::REG_OFFSET, 0, 16'h8000, 0, 0, 0},
      '{ROW_TICK, 0, 0, 0, 1, -32768, 1},
      '{ROW_TICK, 0, 100, 50, 1, -32718, 0},
      '{ROW_CSR, wpid_pkg::REG_OFFSET, 0, 16'h7FFF, 0, 0, 0},
      '{ROW_TICK, 0, 16383, 5, 1, 32767, 1},
      // zero denominator acts as one
      '{ROW_CSR, wpid_pkg::REG_PROP_DEN, 0, 16'h0000, 0, 0, 0},
      '{ROW_TICK, 0, 200, 100, 1, 32867, 0},
      '{ROW_CSR, wpid_pkg::REG_RATE, 0, 16'h0000, 0, 0, 0},
      '{ROW_CSR, wpid_pkg::REG_PROP_NUM, 0, 16'hFFFF, 0, 0, 0},
      '{ROW_CSR, wpid_pkg::REG_INTEG_NUM, 0, 16'hFFFF, 0, 0, 0},
      '{ROW_CSR, wpid_pkg::REG_INTEG_DEN, 0, 16'h0000, 0, 0, 0},
      '{ROW_CSR, wpid_pkg::REG_DERIV_NUM, 0, 16'hFFFF, 0, 0, 0},
      '{ROW_CSR, wpid_pkg::REG_DERIV_DEN, 0, 16'h0000, 0, 0, 0},
      // clip high then low
      '{ROW_TICK, 0, 16382, 1, 0, 0, 0},
      '{ROW_TICK, 0, 1, 16382, 0, 0, 0},
      '{ROW_CSR, IDX_PAST_END, 0, 16'h0005, 0, 0, 0},
      '{ROW_CSR, IDX_TOP, 0, 16'hFFFF, 0, 0, 0},
      '{ROW_TICK, 0, 5000, 5000, 0, 0, 0},
      '{ROW_TICK, 0, 9000, 3000, 0, 0, 0}
   };

   windowed_pid_joint_controller dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint at_least_one(logic [wpid_pkg::GAIN_W-1:0] v);
      return (v == '0) ? 64'sd1 : longint'(v);
   endfunction

   function automatic longint gain_apply(longint x, logic [wpid_pkg::GAIN_W-1:0] num,
                                         logic [wpid_pkg::GAIN_W-1:0] den);
      return (x * longint'(num)) / at_least_one(den);
   endfunction

   function automatic void reset_joint();
      logic [wpid_pkg::GAIN_W-1:0] dflt [0:7];
      dflt = '{16'd1, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1000, 16'd0};
      gain_reg = dflt;
      foreach (integ_err[i]) integ_err[i] = 0;
      foreach (deriv_err[i]) deriv_err[i] = 0;
      integ_acc = 0;
      integ_pos = 0;
      deriv_pos = 0;
   endfunction

   function automatic drive_word_type joint_drive(logic [wpid_pkg::POS_W-1:0] act,
                                                  logic [wpid_pkg::POS_W-1:0] des);
      longint err, rate, err_i, err_d, total, offs;
      drive_word_type w;
      rate = at_least_one(gain_reg[wpid_pkg::REG_RATE]);
      offs = longint'($signed(gain_reg[wpid_pkg::REG_OFFSET]));
      err = longint'(act) - longint'(des);
      integ_acc = integ_acc - integ_err[integ_pos] + err;
      err_i = integ_acc / rate;
      integ_err[integ_pos] = err;
      integ_pos = (integ_pos + 1) % wpid_pkg::INTEG_WIN;
      err_d = ((err - deriv_err[deriv_pos]) * rate) / wpid_pkg::DERIV_WIN;
      deriv_err[deriv_pos] = err;
      deriv_pos = (deriv_pos + 1) % wpid_pkg::DERIV_WIN;
      total = gain_apply(err, gain_reg[wpid_pkg::REG_PROP_NUM],
                         gain_reg[wpid_pkg::REG_PROP_DEN])
            + gain_apply(err_i, gain_reg[wpid_pkg::REG_INTEG_NUM],
                         gain_reg[wpid_pkg::REG_INTEG_DEN])
            + gain_apply(err_d, gain_reg[wpid_pkg::REG_DERIV_NUM],
                         gain_reg[wpid_pkg::REG_DERIV_DEN])
            + offs;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      w.flt = (act == '0) || (act == wpid_pkg::ENC_RAIL);
      if (w.flt) total = offs;
      w.drv = wpid_pkg::OUT_W'(total);
      return w;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // a word is taken at the posedge following a negedge with ready seen high
   task automatic send_tick(logic [wpid_pkg::POS_W-1:0] act,
                            logic [wpid_pkg::POS_W-1:0] des, bit typed,
                            drive_word_type typed_word);
      int gap;
      drive_word_type w;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_actual_position <= act;
      req_desired_position <= des;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      w = joint_drive(act, des);
      drive_q.push_back(typed ? typed_word : w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (drive_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [wpid_pkg::CSR_IDX_W-1:0] idx,
                            logic [wpid_pkg::GAIN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx < 8) gain_reg[idx] = val;
   endtask

   function automatic logic [wpid_pkg::GAIN_W-1:0] draw_gain(bit den);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return wpid_pkg::GAIN_W'($urandom_range(0, 65535));
      if (r == 1) return wpid_pkg::GAIN_W'($urandom_range(den ? 1 : 0, 16));
      return wpid_pkg::GAIN_W'($urandom_range(den ? 1 : 0, 512));
   endfunction

   // receiving side
   initial begin
      int stall;
      drive_word_type exp_w;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         forever begin
            @(negedge clock);
            if (rsp_valid) break;
         end
         if (drive_q.size() == 0) begin
            fails++;
            $display("%0t: unexpected word drive=%0d fault=%0b", $time,
                     rsp_drive_value, rsp_encoder_fault);
         end else begin
            exp_w = drive_q.pop_front();
            checked++;
            if (exp_w.flt) faults_seen++;
            if (exp_w.drv == 32'sh7FFFFFFF || exp_w.drv == 32'sh80000000) clipped_seen++;
            if (rsp_drive_value !== exp_w.drv) begin
               fails++;
               $display("%0t: drive_value expected %0d actual %0d", $time,
                        exp_w.drv, rsp_drive_value);
            end
            if (rsp_encoder_fault !== exp_w.flt) begin
               fails++;
               $display("%0t: encoder_fault expected %0b actual %0b", $time,
                        exp_w.flt, rsp_encoder_fault);
            end
         end
         @(posedge clock);
      end
   end

   // watchdog on cycles without any handshake
   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic [wpid_pkg::POS_W-1:0] act, des;
      drive_word_type tw;
      int r;
      fails = 0;
      checked = 0;
      faults_seen = 0;
      clipped_seen = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_actual_position = '0;
      req_desired_position = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset_joint();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            tw.drv = plan[i].drv;
            tw.flt = plan[i].flt;
            send_tick(plan[i].act, wpid_pkg::POS_W'(plan[i].val), plan[i].typed, tw);
         end
      end

      des = 8000;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         for (int g = 0; g < 8; g++) begin
            if (p == 0)
               write_reg(wpid_pkg::CSR_IDX_W'(g),
                         (g == wpid_pkg::REG_OFFSET) ? 16'h7FFF : 16'hFFFF);
            else if (p == 1)
               write_reg(wpid_pkg::CSR_IDX_W'(g),
                         (g == wpid_pkg::REG_OFFSET) ? 16'h8000 : 16'h0000);
            else if (g == wpid_pkg::REG_OFFSET)
               write_reg(wpid_pkg::CSR_IDX_W'(g),
                         wpid_pkg::GAIN_W'($urandom_range(0, 65535)));
            else if (g == wpid_pkg::REG_RATE)
               write_reg(wpid_pkg::CSR_IDX_W'(g),
                         wpid_pkg::GAIN_W'($urandom_range(1, 65535)));
            else
               write_reg(wpid_pkg::CSR_IDX_W'(g),
                         draw_gain(g == wpid_pkg::REG_PROP_DEN ||
                                   g == wpid_pkg::REG_INTEG_DEN ||
                                   g == wpid_pkg::REG_DERIV_DEN));
         end
         if ($urandom_range(0, 1))
            write_reg(wpid_pkg::CSR_IDX_W'($urandom_range(8, 255)), 16'h0001);
         for (int k = 0; k < PHASE_TICKS; k++) begin
            if (k % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (k == PHASE_TICKS / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 5) des = wpid_pkg::POS_W'($urandom_range(1, POS_MAX - 1));
            if (r < 4) act = $urandom_range(0, 1) ? '0 : wpid_pkg::ENC_RAIL;
            else if (r < 20) begin
               act = wpid_pkg::POS_W'($urandom_range(0, POS_MAX));
               des = wpid_pkg::POS_W'($urandom_range(0, POS_MAX));
            end else begin
               // joint settling around its target
               int pos;
               pos = int'(des) + $urandom_range(0, 400) - 200;
               if (pos < 1) pos = 1;
               if (pos > POS_MAX - 1) pos = POS_MAX - 1;
               act = wpid_pkg::POS_W'(pos);
            end
            send_tick(act, des, 1'b0, tw);
         end
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      wait (drive_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d drive words over %0d gain settings, %0d encoder faults",
               checked, PHASES + 2, faults_seen);
      $display("and %0d clipped drives, with zero and full-scale registers", clipped_seen);
      if (fails == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
src/wpid_pkg.sv
src/wpid_ram.sv
src/wpid_ctrl.sv
src/wpid_datapath.sv
src/windowed_pid_joint_controller.sv
bench/tb.sv
